[sv/fau_pkg.sv]
// Package for the fraction arithmetic unit: request types, control word layout,
// operation codes and the microprogram table used by the sequencer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fau_pkg;

    // Default operand width and the fixed field widths of the requests.
    localparam int FAU_OPERAND_WIDTH = 32;
    localparam int FUNC_W            = 3;
    localparam int IN_NUM_W          = 32;
    localparam int IN_DEN_W          = 31;
    localparam int OUT_NUM_W         = 64;
    localparam int OUT_DEN_W         = 63;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CMP = 3'd4;

    // Input and output requests.
    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [IN_NUM_W-1:0] left_num;
        logic [IN_DEN_W-1:0]        left_den;
        logic signed [IN_NUM_W-1:0] right_num;
        logic [IN_DEN_W-1:0]        right_den;
    } t_fau_in;

    typedef struct packed {
        logic signed [OUT_NUM_W-1:0] result_num;
        logic [OUT_DEN_W-1:0]        result_den;
        logic                        operands_equal;
        logic                        zero_divisor;
    } t_fau_out;

    // Microprogram address.
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    // Multiplier operand pairs.
    typedef enum logic [1:0] {
        MUL_LN_RD,
        MUL_LD_RN,
        MUL_LN_RN,
        MUL_LD_RD
    } t_mul_sel;

    // Datapath actions.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_NUM_LOAD,
        ACT_NUM_ADD,
        ACT_NUM_SUB,
        ACT_DEN_LOAD,
        ACT_DEN_FIX,
        ACT_ABS,
        ACT_GCD,
        ACT_DIV_INIT,
        ACT_DIV,
        ACT_OUT_FRAC,
        ACT_OUT_CMP,
        ACT_OUT_NONE
    } t_act;

    // Sequencing conditions.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_FUNC,
        COND_GCD_LOOP,
        COND_DIV_LOOP,
        COND_OUT
    } t_cond;

    typedef struct packed {
        t_mul_sel mul;
        t_act     act;
        t_cond    cond;
        t_upc     target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_mul_sel mul;
        t_act     act;
        logic     done;
    } t_seq_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              gcd_busy;
        logic              div_last;
    } t_dp_status;

    // Microprogram addresses.
    localparam t_upc UA_DISPATCH = 5'd0;
    localparam t_upc UA_ADD      = 5'd1;
    localparam t_upc UA_ADD_ACC  = 5'd2;
    localparam t_upc UA_SUB      = 5'd3;
    localparam t_upc UA_SUB_ACC  = 5'd4;
    localparam t_upc UA_MUL      = 5'd5;
    localparam t_upc UA_MUL_LOAD = 5'd6;
    localparam t_upc UA_DIV      = 5'd7;
    localparam t_upc UA_DEN      = 5'd8;
    localparam t_upc UA_DEN_FIX  = 5'd9;
    localparam t_upc UA_ABS      = 5'd10;
    localparam t_upc UA_GCD      = 5'd11;
    localparam t_upc UA_DIV_INIT = 5'd12;
    localparam t_upc UA_DIV_LOOP = 5'd13;
    localparam t_upc UA_OUT_FRAC = 5'd14;
    localparam t_upc UA_OUT_CMP  = 5'd15;
    localparam t_upc UA_OUT_NONE = 5'd16;

    // Dispatch table: first program step of each operation.
    function automatic t_upc fau_func_target(input logic [FUNC_W-1:0] func);
        t_upc target;
        case (func)
            FUNC_ADD: target = UA_ADD;
            FUNC_SUB: target = UA_SUB;
            FUNC_MUL: target = UA_MUL;
            FUNC_DIV: target = UA_DIV;
            FUNC_CMP: target = UA_OUT_CMP;
            default:  target = UA_OUT_NONE;
        endcase
        return target;
    endfunction

    // Microprogram. A product selected in one step is registered and used by
    // the next step, so the multiplier works one step ahead of the adder.
    function automatic t_uword fau_urom(input t_upc pc);
        t_uword w;
        case (pc)
            UA_DISPATCH: w = '{MUL_LN_RD, ACT_NONE,     COND_FUNC,     UA_DISPATCH};
            UA_ADD:      w = '{MUL_LD_RN, ACT_NUM_LOAD, COND_NEXT,     UA_DISPATCH};
            UA_ADD_ACC:  w = '{MUL_LD_RD, ACT_NUM_ADD,  COND_JUMP,     UA_DEN};
            UA_SUB:      w = '{MUL_LD_RN, ACT_NUM_LOAD, COND_NEXT,     UA_DISPATCH};
            UA_SUB_ACC:  w = '{MUL_LD_RD, ACT_NUM_SUB,  COND_JUMP,     UA_DEN};
            UA_MUL:      w = '{MUL_LN_RN, ACT_NONE,     COND_NEXT,     UA_DISPATCH};
            UA_MUL_LOAD: w = '{MUL_LD_RD, ACT_NUM_LOAD, COND_JUMP,     UA_DEN};
            UA_DIV:      w = '{MUL_LD_RN, ACT_NUM_LOAD, COND_NEXT,     UA_DISPATCH};
            UA_DEN:      w = '{MUL_LN_RD, ACT_DEN_LOAD, COND_NEXT,     UA_DISPATCH};
            UA_DEN_FIX:  w = '{MUL_LN_RD, ACT_DEN_FIX,  COND_NEXT,     UA_DISPATCH};
            UA_ABS:      w = '{MUL_LN_RD, ACT_ABS,      COND_NEXT,     UA_DISPATCH};
            UA_GCD:      w = '{MUL_LN_RD, ACT_GCD,      COND_GCD_LOOP, UA_GCD};
            UA_DIV_INIT: w = '{MUL_LN_RD, ACT_DIV_INIT, COND_NEXT,     UA_DISPATCH};
            UA_DIV_LOOP: w = '{MUL_LN_RD, ACT_DIV,      COND_DIV_LOOP, UA_DIV_LOOP};
            UA_OUT_FRAC: w = '{MUL_LN_RD, ACT_OUT_FRAC, COND_OUT,      UA_DISPATCH};
            UA_OUT_CMP:  w = '{MUL_LN_RD, ACT_OUT_CMP,  COND_OUT,      UA_DISPATCH};
            UA_OUT_NONE: w = '{MUL_LN_RD, ACT_OUT_NONE, COND_OUT,      UA_DISPATCH};
            default:     w = '{MUL_LN_RD, ACT_OUT_NONE, COND_OUT,      UA_DISPATCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/fau_sequencer.sv]
// Microprogram sequencer of the fraction arithmetic unit: program counter,
// table lookup and conditional jumps. Depends on fau_pkg.
`default_nettype none

module fau_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_free,
    input  fau_pkg::t_dp_status  i_status,
    output fau_pkg::t_seq_ctrl   o_ctrl,
    output logic                 o_busy
);
    import fau_pkg::*;

    logic   r_busy;
    logic   n_busy;
    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uword;

    assign uword  = fau_urom(r_pc);
    assign o_busy = r_busy;

    // Next program counter and the control word handed to the datapath.
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        o_ctrl.mul  = MUL_LN_RD;
        o_ctrl.act  = ACT_NONE;
        o_ctrl.done = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = UA_DISPATCH;
            end
        end else begin
            o_ctrl.mul = uword.mul;
            o_ctrl.act = uword.act;
            case (uword.cond)
                COND_NEXT: begin
                    n_pc = r_pc + UPC_W'(1);
                end
                COND_JUMP: begin
                    n_pc = uword.target;
                end
                COND_FUNC: begin
                    n_pc = fau_func_target(i_status.func);
                end
                COND_GCD_LOOP: begin
                    n_pc = i_status.gcd_busy ? uword.target : r_pc + UPC_W'(1);
                end
                COND_DIV_LOOP: begin
                    n_pc = i_status.div_last ? r_pc + UPC_W'(1) : uword.target;
                end
                COND_OUT: begin
                    // Hand the result over once the output register can take it.
                    if (i_out_free) begin
                        o_ctrl.done = 1'b1;
                        n_busy      = 1'b0;
                    end
                end
                default: begin
                    n_pc = UA_OUT_NONE;
                end
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UA_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

[sv/fau_datapath.sv]
// Datapath of the fraction arithmetic unit: operand latch, multiplier,
// accumulator, binary GCD unit and two restoring dividers. Depends on fau_pkg.
`default_nettype none

module fau_datapath #(
    parameter int OPERAND_WIDTH = fau_pkg::FAU_OPERAND_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  fau_pkg::t_fau_in    i_in,
    input  fau_pkg::t_seq_ctrl  i_ctrl,
    output fau_pkg::t_dp_status o_status,
    output fau_pkg::t_fau_out   o_result
);
    import fau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(PW);
    localparam int CW = $clog2(PW + 1);

    t_fau_in              r_in;
    logic signed [W-1:0]  ln;
    logic signed [W-1:0]  ld;
    logic signed [W-1:0]  rn;
    logic signed [W-1:0]  rd;
    logic signed [W-1:0]  mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]        r_num;
    logic [PW-1:0]        r_den;
    logic                 r_zero;
    logic                 r_flip;
    logic                 r_neg;
    logic [PW-1:0]        r_ga;
    logic [PW-1:0]        r_gb;
    logic [KW-1:0]        r_k;
    logic [PW-1:0]        r_dv;
    logic [PW-1:0]        r_qn;
    logic [PW-1:0]        r_qd;
    logic [PW-1:0]        r_rn;
    logic [PW-1:0]        r_rd;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        mag;
    logic [2*PW-1:0]      step_n;
    logic [2*PW-1:0]      step_d;
    logic signed [PW-1:0] qs;
    logic                 equal;

    // One step of restoring division: returns the new remainder and quotient.
    function automatic logic [2*PW-1:0] div_step(
        input logic [PW-1:0] rem,
        input logic [PW-1:0] q,
        input logic [PW-1:0] dv
    );
        logic [PW-1:0] sh;
        sh = {rem[PW-2:0], q[PW-1]};
        if (sh >= dv) begin
            return {sh - dv, q[PW-2:0], 1'b1};
        end
        return {sh, q[PW-2:0], 1'b0};
    endfunction

    // Operands: numerators taken as their low W bits, denominators zero-extended to W bits.
    assign ln = r_in.left_num[W-1:0];
    assign rn = r_in.right_num[W-1:0];
    assign ld = {1'b0, r_in.left_den[W-2:0]};
    assign rd = {1'b0, r_in.right_den[W-2:0]};

    // Multiplier operand selection.
    always_comb begin
        case (i_ctrl.mul)
            MUL_LN_RD: begin mul_a = ln; mul_b = rd; end
            MUL_LD_RN: begin mul_a = ld; mul_b = rn; end
            MUL_LN_RN: begin mul_a = ln; mul_b = rn; end
            MUL_LD_RD: begin mul_a = ld; mul_b = rd; end
            default:   begin mul_a = ln; mul_b = rd; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Absolute value of the accumulated numerator.
    assign mag    = r_num[PW-1] ? (~r_num + PW'(1)) : r_num;
    assign step_n = div_step(r_rn, r_qn, r_dv);
    assign step_d = div_step(r_rd, r_qd, r_dv);

    // Status for the sequencer.
    assign o_status.func     = r_in.func;
    assign o_status.gcd_busy = (r_ga != '0);
    assign o_status.div_last = (r_cnt == CW'(1));

    // Operand latch.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_in;
        end
    end

    // Registered product, one step ahead of its use.
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    // Accumulator, sign handling, GCD and division steps.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            ACT_NUM_LOAD: begin
                r_num <= r_prod;
            end
            ACT_NUM_ADD: begin
                r_num <= r_num + r_prod;
            end
            ACT_NUM_SUB: begin
                r_num <= r_num - r_prod;
            end
            ACT_DEN_LOAD: begin
                r_den  <= r_prod;
                r_zero <= 1'b0;
                r_flip <= 1'b0;
            end
            ACT_DEN_FIX: begin
                // A zero denominator becomes one; a negative one flips sign.
                if (r_den == '0) begin
                    r_den  <= PW'(1);
                    r_zero <= 1'b1;
                end else if (r_den[PW-1]) begin
                    r_den  <= ~r_den + PW'(1);
                    r_flip <= 1'b1;
                end
            end
            ACT_ABS: begin
                r_num <= mag;
                r_neg <= r_num[PW-1] ^ r_flip;
                r_ga  <= mag;
                r_gb  <= r_den;
                r_k   <= '0;
            end
            ACT_GCD: begin
                // Binary GCD; the common power of two is counted in r_k.
                if (r_ga != '0) begin
                    case ({r_ga[0], r_gb[0]})
                        2'b00: begin
                            r_ga <= r_ga >> 1;
                            r_gb <= r_gb >> 1;
                            r_k  <= r_k + KW'(1);
                        end
                        2'b01: begin
                            r_ga <= r_ga >> 1;
                        end
                        2'b10: begin
                            r_gb <= r_gb >> 1;
                        end
                        default: begin
                            if (r_ga >= r_gb) begin
                                r_ga <= r_ga - r_gb;
                            end else begin
                                r_ga <= r_gb;
                                r_gb <= r_ga;
                            end
                        end
                    endcase
                end
            end
            ACT_DIV_INIT: begin
                r_dv  <= r_gb << r_k;
                r_qn  <= r_num;
                r_qd  <= r_den;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= CW'(PW);
            end
            ACT_DIV: begin
                r_rn  <= step_n[2*PW-1:PW];
                r_qn  <= step_n[PW-1:0];
                r_rd  <= step_d[2*PW-1:PW];
                r_qd  <= step_d[PW-1:0];
                r_cnt <= r_cnt - CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Result forming.
    assign qs    = r_neg ? (~r_qn + PW'(1)) : r_qn;
    assign equal = (ln == rn) && (ld == rd);

    always_comb begin
        o_result.result_num     = '0;
        o_result.result_den     = OUT_DEN_W'(1);
        o_result.operands_equal = 1'b0;
        o_result.zero_divisor   = 1'b0;
        case (i_ctrl.act)
            ACT_OUT_FRAC: begin
                o_result.result_num   = OUT_NUM_W'(qs);
                o_result.result_den   = OUT_DEN_W'(r_qd);
                o_result.zero_divisor = r_zero;
            end
            ACT_OUT_CMP: begin
                o_result.operands_equal = equal;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/fraction_arithmetic_unit.sv]
// Fraction arithmetic unit: add, subtract, multiply, divide or compare two fractions.
// Add, subtract, multiply and divide pass through the binary GCD loop and a divider
// that yields a 2W-bit quotient (W = OPERAND_WIDTH); compare and unused codes skip both.
// The GCD loop and the divider loop set the latency. One request at a time:
// the next is accepted the cycle after the result enters the output register.
// Synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module fraction_arithmetic_unit #(
    parameter int OPERAND_WIDTH = fau_pkg::FAU_OPERAND_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fau_pkg::t_fau_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fau_pkg::t_fau_out o_out
);
    import fau_pkg::*;

    logic       accept;
    logic       out_free;
    logic       busy;
    t_seq_ctrl  seq_ctrl;
    t_dp_status dp_status;
    t_fau_out   dp_result;
    logic       r_out_valid;
    t_fau_out   r_out;

    assign accept      = i_in_valid && !busy;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Control program.
    fau_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_ctrl     (seq_ctrl),
        .o_busy     (busy)
    );

    // Arithmetic.
    fau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_in     (i_in),
        .i_ctrl   (seq_ctrl),
        .o_status (dp_status),
        .o_result (dp_result)
    );

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (seq_ctrl.done) begin
            r_out <= dp_result;
        end
    end

    // A waiting result is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctrl.done |-> !(r_out_valid && i_out_stall))
        else $error("result written over a waiting result");

    // An accepted request keeps the input stalled until its result is handed over.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("sequencer not busy after accepting a request");

    // A delivered denominator is never zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.result_den != '0))
        else $error("zero result denominator");

    // Compare and divisor flags never appear together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.operands_equal && r_out.zero_divisor))
        else $error("equal and zero divisor flags both set");

endmodule

`default_nettype wire
